### rtl/core/assert_macros.svh
// Assertion macros shared by the angle and gyro fusion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KAGF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kagf assertion failed");
`define KAGF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kagf implication failed");
`else
`define KAGF_ASSERT(lbl, prop)
`define KAGF_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### rtl/core/kagf_pkg.sv
// Shared types, widths and saturation helpers of the angle and gyro fusion block.
package kagf_pkg;

    localparam int DAT_W = 32;
    localparam int SUM_W = 42;
    localparam int A_W   = 35;
    localparam int B_W   = 33;
    localparam int P_W   = 40;

    localparam logic signed [DAT_W-1:0] Q30_ONE = 32'sd1073741824;

    typedef struct packed {
        logic [30:0] angle_noise;
        logic [30:0] bias_noise;
        logic [30:0] measure_noise;
        logic [29:0] time_step;
    } t_cfg;

    typedef struct packed {
        logic                  go;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                    go;
        logic signed [DAT_W-1:0] num;
        logic [DAT_W-1:0]        den;
    } t_div_req;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        (SUM_W'(1) <<< (DAT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    function automatic logic signed [DAT_W-1:0] sat_dat(input logic signed [SUM_W-1:0] v);
        logic signed [DAT_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DAT_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DAT_W-1:0];
        end else begin
            r = v[DAT_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/kagf_mul.sv
// Multi-cycle Q30 multiplier with rounding, built on one 34 by 16 bit partial product.
module kagf_mul
    import kagf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mul_req              i_req,
    output logic                  o_done,
    output logic signed [P_W-1:0] o_p
);

    typedef enum logic [1:0] {ST_IDLE, ST_LO, ST_HI, ST_RND} t_state;

    t_state      r_state;
    logic        r_neg;
    logic [33:0] r_ma;
    logic [31:0] r_mb;
    logic [65:0] r_acc;

    logic [A_W-1:0] w_na;
    logic [B_W-1:0] w_nb;
    logic [15:0]    w_half;
    logic [49:0]    w_pp;
    logic [65:0]    w_rnd;
    logic [35:0]    w_r;

    assign w_na   = -i_req.a;
    assign w_nb   = -i_req.b;
    assign w_half = (r_state == ST_LO) ? r_mb[15:0] : r_mb[31:16];
    assign w_pp   = r_ma * w_half;
    assign w_rnd  = r_acc + 66'h0000_0000_2000_0000;
    assign w_r    = w_rnd[65:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.go) begin
                        r_neg   <= i_req.a[A_W-1] ^ i_req.b[B_W-1];
                        r_ma    <= i_req.a[A_W-1] ? w_na[33:0] : i_req.a[33:0];
                        r_mb    <= i_req.b[B_W-1] ? w_nb[31:0] : i_req.b[31:0];
                        r_state <= ST_LO;
                    end
                end
                ST_LO: begin
                    r_acc   <= {16'b0, w_pp};
                    r_state <= ST_HI;
                end
                ST_HI: begin
                    r_acc   <= r_acc + {w_pp, 16'b0};
                    r_state <= ST_RND;
                end
                ST_RND: begin
                    o_p     <= r_neg ? -$signed({4'b0, w_r}) : $signed({4'b0, w_r});
                    o_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/kagf_div.sv
// Bit-serial restoring divider that forms a rounded, saturated Q30 gain.
module kagf_div
    import kagf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    output logic                    o_done,
    output logic signed [DAT_W-1:0] o_q
);

    localparam int Q_BITS = 31;

    typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_ITER, ST_FIN} t_state;

    t_state      r_state;
    logic        r_neg;
    logic        r_ovf;
    logic [31:0] r_mn;
    logic [31:0] r_d;
    logic [31:0] r_rem;
    logic [30:0] r_nlo;
    logic [30:0] r_q;
    logic [4:0]  r_cnt;

    logic [31:0] w_nn;
    logic [62:0] w_n;
    logic [32:0] w_t;
    logic        w_ge;
    logic [32:0] w_sub;

    assign w_nn  = -i_req.num;
    assign w_n   = {1'b0, r_mn, 30'b0} + {32'b0, r_d[31:1]};
    assign w_t   = {r_rem, r_nlo[30]};
    assign w_ge  = w_t >= {1'b0, r_d};
    assign w_sub = w_t - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.go) begin
                        r_neg   <= i_req.num[DAT_W-1];
                        r_mn    <= i_req.num[DAT_W-1] ? w_nn : i_req.num;
                        r_d     <= i_req.den;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    // A quotient of 2^31 or more saturates either way.
                    r_ovf   <= w_n >= {r_d, 31'b0};
                    r_rem   <= w_n[62:31];
                    r_nlo   <= w_n[30:0];
                    r_cnt   <= '0;
                    r_state <= ST_ITER;
                end
                ST_ITER: begin
                    r_rem <= w_ge ? w_sub[31:0] : w_t[31:0];
                    r_q   <= {r_q[29:0], w_ge};
                    r_nlo <= {r_nlo[29:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(Q_BITS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (r_ovf) begin
                        o_q <= r_neg ? SAT_LO[DAT_W-1:0] : SAT_HI[DAT_W-1:0];
                    end else begin
                        o_q <= r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
                    end
                    o_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/kagf_core.sv
// Sequencer and filter state: drives the shared multiplier and divider through one update.
module kagf_core
    import kagf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_start,
    input  logic signed [DAT_W-1:0] i_angle_meas,
    input  logic signed [DAT_W-1:0] i_rate_meas,
    input  logic                    i_out_free,
    output logic                    o_idle,
    output logic                    o_done,
    output logic signed [DAT_W-1:0] o_angle_est,
    output logic signed [DAT_W-1:0] o_rate_est
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_GAIN, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_RC, OP_PD, OP_C11, OP_BN, OP_K0T0, OP_K0T1, OP_K1T0, OP_K1T1, OP_EK0, OP_EK1
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic   r_div_k1;

    logic signed [DAT_W-1:0] r_angle, r_bias, r_c00, r_c01, r_c10, r_c11;
    logic signed [DAT_W-1:0] r_am, r_rm, r_t0, r_t1, r_k0, r_k1;
    logic signed [DAT_W:0]   r_err;
    logic [DAT_W-1:0]        r_e;

    t_mul_req                w_mreq;
    t_div_req                w_dreq;
    logic                    w_mdone, w_ddone;
    logic signed [P_W-1:0]   w_p;
    logic signed [DAT_W-1:0] w_q;
    logic signed [DAT_W-1:0] w_rc;
    logic signed [DAT_W:0]   w_err, w_e;
    logic signed [B_W-1:0]   w_dt;

    assign w_rc  = sat_dat(SUM_W'(r_rm) - SUM_W'(r_bias));
    assign w_dt  = $signed({3'b0, i_cfg.time_step});
    assign w_err = (DAT_W+1)'(r_am) - (DAT_W+1)'(r_angle);
    assign w_e   = (DAT_W+1)'($signed({1'b0, i_cfg.measure_noise})) + (DAT_W+1)'(r_c00);

    always_comb begin
        w_mreq.go = (r_state == ST_MUL_GO);
        w_mreq.a  = '0;
        w_mreq.b  = '0;
        case (r_op)
            OP_RC: begin
                w_mreq.a = A_W'(w_rc);
                w_mreq.b = w_dt;
            end
            OP_PD: begin
                w_mreq.a = A_W'($signed({1'b0, i_cfg.angle_noise})) - A_W'(r_c01)
                           - A_W'(r_c10);
                w_mreq.b = w_dt;
            end
            OP_C11: begin
                w_mreq.a = A_W'(r_c11);
                w_mreq.b = w_dt;
            end
            OP_BN: begin
                w_mreq.a = $signed({4'b0, i_cfg.bias_noise});
                w_mreq.b = w_dt;
            end
            OP_K0T0: begin
                w_mreq.a = A_W'(r_k0);
                w_mreq.b = B_W'(r_t0);
            end
            OP_K0T1: begin
                w_mreq.a = A_W'(r_k0);
                w_mreq.b = B_W'(r_t1);
            end
            OP_K1T0: begin
                w_mreq.a = A_W'(r_k1);
                w_mreq.b = B_W'(r_t0);
            end
            OP_K1T1: begin
                w_mreq.a = A_W'(r_k1);
                w_mreq.b = B_W'(r_t1);
            end
            OP_EK0: begin
                w_mreq.a = A_W'(r_err);
                w_mreq.b = B_W'(r_k0);
            end
            OP_EK1: begin
                w_mreq.a = A_W'(r_err);
                w_mreq.b = B_W'(r_k1);
            end
            default: ;
        endcase
    end

    assign w_dreq.go  = (r_state == ST_DIV_GO);
    assign w_dreq.num = r_div_k1 ? r_c10 : r_c00;
    assign w_dreq.den = r_e;

    kagf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_p     (w_p)
    );

    kagf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    assign o_idle      = (r_state == ST_IDLE);
    assign o_done      = (r_state == ST_OUT) && i_out_free;
    assign o_angle_est = r_angle;
    assign o_rate_est  = sat_dat(SUM_W'(r_rm) - SUM_W'(r_bias));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_RC;
            r_div_k1 <= 1'b0;
            r_angle  <= '0;
            r_bias   <= '0;
            r_c00    <= Q30_ONE;
            r_c01    <= '0;
            r_c10    <= '0;
            r_c11    <= Q30_ONE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_am    <= i_angle_meas;
                        r_rm    <= i_rate_meas;
                        r_op    <= OP_RC;
                        r_state <= ST_MUL_GO;
                    end
                end
                ST_MUL_GO: r_state <= ST_MUL_WAIT;
                ST_MUL_WAIT: begin
                    if (w_mdone) begin
                        r_state <= ST_MUL_GO;
                        case (r_op)
                            OP_RC: begin
                                r_angle <= sat_dat(SUM_W'(r_angle) + SUM_W'(w_p));
                                r_op    <= OP_PD;
                            end
                            OP_PD: begin
                                r_c00 <= sat_dat(SUM_W'(r_c00) + SUM_W'(w_p));
                                r_op  <= OP_C11;
                            end
                            OP_C11: begin
                                r_c01 <= sat_dat(SUM_W'(r_c01) - SUM_W'(w_p));
                                r_c10 <= sat_dat(SUM_W'(r_c10) - SUM_W'(w_p));
                                r_op  <= OP_BN;
                            end
                            OP_BN: begin
                                r_c11   <= sat_dat(SUM_W'(r_c11) + SUM_W'(w_p));
                                r_state <= ST_GAIN;
                            end
                            OP_K0T0: begin
                                r_c00 <= sat_dat(SUM_W'(r_t0) - SUM_W'(w_p));
                                r_op  <= OP_K0T1;
                            end
                            OP_K0T1: begin
                                r_c01 <= sat_dat(SUM_W'(r_t1) - SUM_W'(w_p));
                                r_op  <= OP_K1T0;
                            end
                            OP_K1T0: begin
                                r_c10 <= sat_dat(SUM_W'(r_c10) - SUM_W'(w_p));
                                r_op  <= OP_K1T1;
                            end
                            OP_K1T1: begin
                                r_c11 <= sat_dat(SUM_W'(r_c11) - SUM_W'(w_p));
                                r_op  <= OP_EK0;
                            end
                            OP_EK0: begin
                                r_angle <= sat_dat(SUM_W'(r_angle) + SUM_W'(w_p));
                                r_op    <= OP_EK1;
                            end
                            OP_EK1: begin
                                r_bias  <= sat_dat(SUM_W'(r_bias) + SUM_W'(w_p));
                                r_state <= ST_OUT;
                            end
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_GAIN: begin
                    r_err    <= w_err;
                    r_e      <= w_e[DAT_W-1:0];
                    r_t0     <= r_c00;
                    r_t1     <= r_c01;
                    r_div_k1 <= 1'b0;
                    if (!w_e[DAT_W] && (w_e != '0)) begin
                        r_state <= ST_DIV_GO;
                    end else begin
                        // Without a positive innovation variance the gains are zero.
                        r_k0    <= '0;
                        r_k1    <= '0;
                        r_op    <= OP_K0T0;
                        r_state <= ST_MUL_GO;
                    end
                end
                ST_DIV_GO: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (w_ddone) begin
                        if (r_div_k1) begin
                            r_k1    <= w_q;
                            r_op    <= OP_K0T0;
                            r_state <= ST_MUL_GO;
                        end else begin
                            r_k0     <= w_q;
                            r_div_k1 <= 1'b1;
                            r_state  <= ST_DIV_GO;
                        end
                    end
                end
                ST_OUT: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/kalman_angle_gyro_fusion.sv
// Top level of the two-state Kalman angle and gyro bias fusion block.
//
// Usage: each beat on the slave stream carries one accelerometer angle and one
// gyro rate, both signed Q16.16. The block runs one predict and correct step of
// a Kalman filter over angle and gyro bias, and returns one beat on the master
// stream with the filtered angle and the bias-corrected rate.
// The configuration channel writes the noise terms and the sample period by
// register index (0 angle noise, 1 bias noise, 2 measurement noise, 3 time
// step); other indexes are ignored. Write only while the block is idle.
// Each beat takes ten products on the shared multiplier and, for a positive
// innovation variance, two gains on the serial divider, one quotient bit per
// cycle. The slave side is not ready while a beat is being worked on.
// A finished result sits in an output register; the next input beat may be
// taken while it waits. If the receiver stalls, the following result is held
// inside the core until that register is free.
// Reset (synchronous, active low) restores the register defaults, clears angle
// and bias and sets the covariance to the identity.
`include "assert_macros.svh"
module kalman_angle_gyro_fusion
    import kagf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // angle_meas [31:0], rate_meas [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // angle_est [31:0], rate_est [63:32]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    localparam logic [7:0] REG_ANGLE_NOISE   = 8'd0;
    localparam logic [7:0] REG_BIAS_NOISE    = 8'd1;
    localparam logic [7:0] REG_MEASURE_NOISE = 8'd2;
    localparam logic [7:0] REG_TIME_STEP     = 8'd3;

    t_cfg        r_cfg;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic                    w_idle, w_done, w_out_free, w_start;
    logic signed [DAT_W-1:0] w_angle_est, w_rate_est;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; a write to an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_noise   <= 31'd1073742;
            r_cfg.bias_noise    <= 31'd3221225;
            r_cfg.measure_noise <= 31'd536870912;
            r_cfg.time_step     <= 30'd5368709;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_ANGLE_NOISE:   r_cfg.angle_noise   <= i_cfg_data[30:0];
                REG_BIAS_NOISE:    r_cfg.bias_noise    <= i_cfg_data[30:0];
                REG_MEASURE_NOISE: r_cfg.measure_noise <= i_cfg_data[30:0];
                REG_TIME_STEP:     r_cfg.time_step     <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    // The core only hands over a result when the output register can take it.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_idle;
    assign w_start       = s_axis_tvalid && w_idle;

    kagf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_start      (w_start),
        .i_angle_meas (s_axis_tdata[31:0]),
        .i_rate_meas  (s_axis_tdata[63:32]),
        .i_out_free   (w_out_free),
        .o_idle       (w_idle),
        .o_done       (w_done),
        .o_angle_est  (w_angle_est),
        .o_rate_est   (w_rate_est)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
            r_out_data  <= {w_rate_est, w_angle_est};
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `KAGF_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    `KAGF_ASSERT_IMP(a_done_needs_room, w_done, !r_out_valid || m_axis_tready)
    `KAGF_ASSERT(a_valid_from_done, $rose(r_out_valid) |-> $past(w_done))

endmodule

### sim/tb_kalman_angle_gyro_fusion.sv
// Self-checking testbench for the Kalman angle and gyro bias fusion block.
`timescale 1ns / 100ps
module tb_kalman_angle_gyro_fusion;

    localparam logic [7:0] REG_ANGLE_NOISE   = 8'd0;
    localparam logic [7:0] REG_BIAS_NOISE    = 8'd1;
    localparam logic [7:0] REG_MEASURE_NOISE = 8'd2;
    localparam logic [7:0] REG_TIME_STEP     = 8'd3;
    localparam logic [7:0] REG_UNUSED_LOW    = 8'd4;
    localparam logic [7:0] REG_UNUSED_HIGH   = 8'd255;

    localparam longint SMP_MAX = 64'sd2147483647;
    localparam longint SMP_MIN = -64'sd2147483648;
    localparam longint Q30_UNIT = 64'sd1073741824;
    localparam int SETTLE_CYCLES = 250;
    localparam int ITEMS_PER_PHASE = 210;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // angle_meas [31:0], rate_meas [63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // angle_est [31:0], rate_est [63:32]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;

    kalman_angle_gyro_fusion DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } t_estimate;

    // Filter state and register copies, kept as wide integers.
    longint unsigned noise_angle, noise_bias, noise_meas, step_dt;
    longint est_angle, est_bias, p00, p01, p10, p11;

    t_estimate pending_estimates[$];
    int errors;
    int items_sent;
    int results_seen;
    bit steady_sink;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint sat32(input longint v);
        return v > SMP_MAX ? SMP_MAX : (v < SMP_MIN ? SMP_MIN : v);
    endfunction

    // Full product scaled down by 2^30, rounded to nearest, ties away from zero.
    function automatic longint q30_mul(input longint a, input longint b);
        logic [127:0] prod;
        longint unsigned ma, mb;
        longint r;
        ma = (a < 0) ? longint'(-a) : longint'(a);
        mb = (b < 0) ? longint'(-b) : longint'(b);
        prod = {64'd0, ma} * {64'd0, mb};
        prod = (prod + (128'd1 << 29)) >> 30;
        r = longint'(prod[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // Rounded num * 2^30 / den, clipped to the signed Q2.30 range.
    function automatic longint q30_div(input longint num, input longint den);
        longint unsigned mn, q, d;
        mn = (num < 0) ? longint'(-num) : longint'(num);
        d = den;
        q = ((mn << 30) + d / 2) / d;
        if (q > (64'd1 << 32)) q = 64'd1 << 32;
        return sat32((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    task automatic filter_reset();
        noise_angle = 1073742;
        noise_bias = 3221225;
        noise_meas = 536870912;
        step_dt = 5368709;
        est_angle = 0;
        est_bias = 0;
        p00 = Q30_UNIT;
        p01 = 0;
        p10 = 0;
        p11 = Q30_UNIT;
    endtask

    // One predict and correct step of the filter, giving the expected beat.
    function automatic t_estimate filter_step(input logic signed [31:0] angle_in,
                                              input logic signed [31:0] rate_in);
        longint am, rm, dt, rc, pd0, innov_var, innov, k0, k1, t0, t1, t10;
        t_estimate res;
        am = angle_in;
        rm = rate_in;
        dt = step_dt;
        k0 = 0;
        k1 = 0;
        rc = sat32(rm - est_bias);
        est_angle = sat32(est_angle + q30_mul(rc, dt));
        pd0 = longint'(noise_angle) - p01 - p10;
        p00 = sat32(p00 + q30_mul(pd0, dt));
        p01 = sat32(p01 - q30_mul(p11, dt));
        p10 = sat32(p10 - q30_mul(p11, dt));
        p11 = sat32(p11 + q30_mul(longint'(noise_bias), dt));
        innov = am - est_angle;
        innov_var = longint'(noise_meas) + p00;
        // A non-positive innovation variance leaves both gains at zero.
        if (innov_var > 0) begin
            k0 = q30_div(p00, innov_var);
            k1 = q30_div(p10, innov_var);
        end
        t0 = p00;
        t1 = p01;
        t10 = p10;
        p00 = sat32(t0 - q30_mul(k0, t0));
        p01 = sat32(t1 - q30_mul(k0, t1));
        p10 = sat32(t10 - q30_mul(k1, t0));
        p11 = sat32(p11 - q30_mul(k1, t1));
        est_angle = sat32(est_angle + q30_mul(innov, k0));
        est_bias = sat32(est_bias + q30_mul(innov, k1));
        res.angle = est_angle[31:0];
        res.rate = 32'(sat32(rm - est_bias));
        return res;
    endfunction

    // Sink side: random stall before each result, with stretches of none.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = steady_sink ? 0 : $urandom_range(0, 9);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_estimate want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_estimates.size() == 0) begin
                $error("unexpected result beat: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_estimates.pop_front();
                if (m_axis_tdata[31:0] !== want.angle) begin
                    $error("angle_est: expected %0d, got %0d", want.angle,
                           $signed(m_axis_tdata[31:0]));
                    errors++;
                end
                if (m_axis_tdata[63:32] !== want.rate) begin
                    $error("rate_est: expected %0d, got %0d", want.rate,
                           $signed(m_axis_tdata[63:32]));
                    errors++;
                end
            end
        end
    end

    // Sends one beat after a random gap. A typed expectation replaces the
    // predicted one, though the filter state still advances.
    task automatic send_sample(input logic [31:0] angle_in, input logic [31:0] rate_in,
                               input bit typed, input t_estimate typed_est);
        int gap;
        t_estimate predicted;
        gap = steady_sink ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rate_in, angle_in};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = filter_step(angle_in, rate_in);
        pending_estimates.push_back(typed ? typed_est : predicted);
        items_sent++;
        steady_sink = (items_sent % 200) < 30;
        @(negedge i_clk);
    endtask

    // Waits until every expected beat has come, then lets the core settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Holds the write beat until the next falling edge; the following write or
    // the next run of samples takes the channel from there.
    task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_ANGLE_NOISE:   noise_angle = value & 32'h7FFF_FFFF;
            REG_BIAS_NOISE:    noise_bias = value & 32'h7FFF_FFFF;
            REG_MEASURE_NOISE: noise_meas = value & 32'h7FFF_FFFF;
            REG_TIME_STEP:     step_dt = value & 32'h3FFF_FFFF;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] an, input logic [31:0] bn,
                             input logic [31:0] mn, input logic [31:0] dt);
        write_reg(REG_ANGLE_NOISE, an);
        write_reg(REG_BIAS_NOISE, bn);
        write_reg(REG_MEASURE_NOISE, mn);
        write_reg(REG_TIME_STEP, dt);
    endtask

    // Mostly plausible tilt angles and rates, with some full-range noise.
    task automatic random_samples(input int count);
        logic [31:0] a, r;
        t_estimate none;
        none = '{default: '0};
        i_cfg_valid <= 1'b0;
        repeat (count) begin
            if ($urandom_range(0, 9) < 8) begin
                a = $urandom_range(0, 180 << 16) - (90 << 16);
                r = $urandom_range(0, 1000 << 16) - (500 << 16);
            end else begin
                a = $urandom;
                r = $urandom;
            end
            send_sample(a, r, 1'b0, none);
        end
    endtask

    typedef struct {
        logic [31:0] angle;
        logic [31:0] rate;
        bit          typed;
        t_estimate   want;
    } t_row;

    t_row directed_rows[$];

    initial begin
        t_estimate zero_est;
        zero_est = '{default: '0};
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        steady_sink = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        filter_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero input straight after reset leaves angle and bias at zero.
        directed_rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b1, zero_est},
            '{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, zero_est},
            '{32'h8000_0000, 32'h0000_0000, 1'b0, zero_est},
            '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, zero_est},
            '{32'h0000_0000, 32'h8000_0000, 1'b0, zero_est},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, zero_est},
            '{32'h8000_0000, 32'h8000_0000, 1'b0, zero_est},
            '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, zero_est},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, zero_est},
            '{32'h0000_0001, 32'h0000_0001, 1'b0, zero_est},
            '{32'h005A_0000, 32'h0001_0000, 1'b0, zero_est},
            '{32'hFFA6_0000, 32'hFFFF_0000, 1'b0, zero_est},
            '{32'h0000_8000, 32'h01F4_0000, 1'b0, zero_est}
        };
        foreach (directed_rows[i])
            send_sample(directed_rows[i].angle, directed_rows[i].rate,
                        directed_rows[i].typed, directed_rows[i].want);
        random_samples(ITEMS_PER_PHASE);

        // The sender holds off here until every beat has been returned.
        drain();
        write_all(32'd1073742, 32'd3221225, 32'd536870912, 32'd5368709);
        write_reg(REG_UNUSED_LOW, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED_HIGH, 32'h0000_0000);
        random_samples(ITEMS_PER_PHASE);

        // Every register at its largest value; bit 31 set to check masking.
        drain();
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_samples(ITEMS_PER_PHASE);

        // Zero angle and bias noise, with measurement noise and period of one.
        drain();
        write_all(32'd0, 32'd0, 32'd1, 32'd1);
        random_samples(ITEMS_PER_PHASE);

        // Zero time step: the prediction leaves the state alone.
        drain();
        write_reg(REG_TIME_STEP, 32'd0);
        random_samples(ITEMS_PER_PHASE / 2);

        // Zero measurement noise with a long period lets the innovation
        // variance reach zero or below and drives the covariance to its limits.
        drain();
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'h3FFF_FFFF);
        random_samples(ITEMS_PER_PHASE / 2);

        repeat (3) begin
            drain();
            write_all($urandom, $urandom, $urandom_range(1, 32'h7FFF_FFFF),
                      $urandom_range(1, 32'h00FF_FFFF));
            random_samples(ITEMS_PER_PHASE);
        end

        drain();
        $display("Sent %0d samples over nine register settings, %0d results checked.",
                 items_sent, results_seen);
        $display("Settings included register extremes, a zero period and zero noise.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
